### src/hpst_pkg.sv
package hpst_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_HALL_EDGE    = 2'd0,
    OP_MONITOR_TICK = 2'd1,
    OP_SET_TRAVEL   = 2'd2,
    OP_SET_POSITION = 2'd3
  } op_e;

  // configuration channel
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MISS_LIMIT       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_UP_ON_HIGH = 4'd1;

  // stream widths, tdata padded to whole bytes
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;

  // reset values and warm-up thresholds
  localparam logic [15:0] POSITION_RESET   = 16'h5000;
  localparam logic [7:0]  MISS_LIMIT_RESET = 8'd10;
  localparam logic [4:0]  WARMUP_THRESHOLD = 5'd28;
  localparam logic [4:0]  WARMUP_HOLD      = 5'd29;

  typedef struct packed {
    logic [7:0] miss_limit;
    logic       count_up_on_high;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic        direction;
    logic [15:0] captured_tick;
    logic [15:0] set_value;
  } item_t;

  typedef struct packed {
    logic [15:0] position;
    logic [15:0] travel;
    logic [15:0] avg_period;
    logic        signal_present;
  } result_t;

endpackage

### src/hpst_cfg_regs.sv
module hpst_cfg_regs
  import hpst_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  logic [CFG_INDEX_W-1:0] index_i,
  input  logic [CFG_DATA_W-1:0]  data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.miss_limit       <= MISS_LIMIT_RESET;
      cfg_q.count_up_on_high <= 1'b1;
    end else if (wr_i) begin
      unique case (index_i)
        REG_MISS_LIMIT:       cfg_q.miss_limit       <= data_i[7:0];
        REG_COUNT_UP_ON_HIGH: cfg_q.count_up_on_high <= data_i[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/hpst_period_avg.sv
module hpst_period_avg #(
  parameter int unsigned AVG_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        upd_i,
  input  logic [15:0] interval_i,
  output logic [15:0] total_o
);

  localparam int unsigned IDX_W   = $clog2(AVG_DEPTH);
  localparam int unsigned QW      = $clog2((2**16 - 1) / AVG_DEPTH + 1);
  localparam int unsigned SHIFT   = 16 + $clog2(AVG_DEPTH);
  localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned PROD_W  = 16 + RECIP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_DEPTH - 1);

  logic [QW-1:0]     slot_q [AVG_DEPTH];
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [15:0]       total_q, total_d;
  logic [PROD_W-1:0] prod;
  logic [QW-1:0]     quot;

  // exact truncating divide by the depth: rounded-up reciprocal, then shift
  assign prod = PROD_W'(interval_i) * PROD_W'(RECIP);
  assign quot = prod[SHIFT +: QW];

  // running sum of the ring: drop the slot being replaced, add the new one
  assign total_d = total_q - 16'(slot_q[idx_q]) + 16'(quot);
  assign idx_d   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign total_o = total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      total_q <= '0;
      for (int k = 0; k < AVG_DEPTH; k++) begin
        slot_q[k] <= '0;
      end
    end else if (upd_i) begin
      idx_q         <= idx_d;
      total_q       <= total_d;
      slot_q[idx_q] <= quot;
    end
  end

endmodule

### src/hpst_tracker.sv
module hpst_tracker
  import hpst_pkg::*;
#(
  parameter int unsigned AVG_DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [15:0] position_q, position_d;
  logic [15:0] travel_q, travel_d;
  logic [15:0] last_tick_q, last_tick_d;
  logic [4:0]  warmup_q, warmup_d;
  logic [15:0] avg_q, avg_d;
  logic [7:0]  miss_q, miss_d;
  logic        present_q, present_d;

  logic [15:0] interval;
  logic [15:0] total_next;
  logic [4:0]  warm_inc;
  logic [7:0]  miss_inc;
  logic        step_up;
  logic        is_edge;

  assign interval = item_i.captured_tick - last_tick_q;
  assign warm_inc = warmup_q + 5'd1;
  assign miss_inc = miss_q + 8'd1;
  assign step_up  = (item_i.direction == cfg_i.count_up_on_high);
  assign is_edge  = fire_i && (item_i.op == OP_HALL_EDGE);

  hpst_period_avg #(
    .AVG_DEPTH(AVG_DEPTH)
  ) u_period_avg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (is_edge),
    .interval_i(interval),
    .total_o   (total_next)
  );

  always_comb begin
    position_d  = position_q;
    travel_d    = travel_q;
    last_tick_d = last_tick_q;
    warmup_d    = warmup_q;
    avg_d       = avg_q;
    miss_d      = miss_q;
    present_d   = present_q;
    unique case (item_i.op)
      OP_HALL_EDGE: begin
        travel_d    = travel_q + 16'd1;
        position_d  = step_up ? position_q + 16'd1 : position_q - 16'd1;
        present_d   = 1'b1;
        miss_d      = '0;
        last_tick_d = item_i.captured_tick;
        warmup_d    = warm_inc;
        if (warm_inc > WARMUP_THRESHOLD) begin
          warmup_d = WARMUP_HOLD;
          avg_d    = total_next;
        end
      end
      OP_MONITOR_TICK: begin
        miss_d = miss_inc;
        if (miss_inc > cfg_i.miss_limit) begin
          present_d   = 1'b0;
          miss_d      = '0;
          avg_d       = '0;
          last_tick_d = '0;
          warmup_d    = '0;
        end
      end
      OP_SET_TRAVEL:   travel_d   = item_i.set_value;
      OP_SET_POSITION: position_d = item_i.set_value;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= POSITION_RESET;
      travel_q    <= '0;
      last_tick_q <= '0;
      warmup_q    <= '0;
      avg_q       <= '0;
      miss_q      <= '0;
      present_q   <= 1'b0;
    end else if (fire_i) begin
      position_q  <= position_d;
      travel_q    <= travel_d;
      last_tick_q <= last_tick_d;
      warmup_q    <= warmup_d;
      avg_q       <= avg_d;
      miss_q      <= miss_d;
      present_q   <= present_d;
    end
  end

  assign res_o.position       = position_d;
  assign res_o.travel         = travel_d;
  assign res_o.avg_period     = avg_d;
  assign res_o.signal_present = present_d;

endmodule

### src/hall_position_speed_tracker.sv
// hall sensor position and speed tracker
//
// every input transaction on the s_axis channel is one operation selected by
// tuser: hall edge, monitor tick, set travel or set position. each one gives
// exactly one result transaction on m_axis: position, travel, average period
// and the signal present flag as they stand after the operation.
// the cfg channel writes miss_limit (index 0) and count_up_on_high (index 1);
// it is always ready and other indexes are dropped. write it only while idle.
//
// an input transaction passes the input register, then the state update and
// the result register, which drives the result transaction. while the
// receiver takes results, one operation is accepted every cycle; the rate is
// set by the state update loop (counters plus running ring sum and one
// divide-by-depth multiply). when the receiver stalls, the result register
// holds and one more item waits in the input register before s_axis_tready_o
// drops.
// reset clears both stages, loads position 0x5000, clears the interval ring
// and puts the registers at miss_limit 10, count_up_on_high 1.
module hall_position_speed_tracker
  import hpst_pkg::*;
#(
  parameter int unsigned AVG_DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // direction[0], captured_tick[16:1], set_value[32:17], zero pad [39:33]
  input  logic [IN_DATA_W-1:0]   s_axis_tdata_i,
  // op[1:0]
  input  logic [IN_USER_W-1:0]   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // position[15:0], travel[31:16], avg_period[47:32], signal_present[48],
  // zero pad [55:49]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t res;
  result_t out_res_q;
  logic    out_valid_q;
  logic    advance;
  logic    fire;
  logic    s_accept;

  // configuration registers, never back-pressured
  assign cfg_ready_o = 1'b1;

  hpst_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i),
    .index_i(cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // pipeline control: the result register moves when empty or being taken
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.op            <= op_e'(s_axis_tuser_i[1:0]);
      in_item_q.direction     <= s_axis_tdata_i[0];
      in_item_q.captured_tick <= s_axis_tdata_i[16:1];
      in_item_q.set_value     <= s_axis_tdata_i[32:17];
    end
  end

  // tracker state, updated when the item leaves the input register
  hpst_tracker #(
    .AVG_DEPTH(AVG_DEPTH)
  ) u_tracker (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_item_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_res_q.signal_present, out_res_q.avg_period,
                            out_res_q.travel, out_res_q.position};

endmodule

### src/hpst_checker.sv
module hpst_checker
  import hpst_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_i,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_i
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result dropped while stalled");

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i))
    else $error("result payload changed while stalled");

  // no result straight out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_i)
    else $error("result valid right after reset");

  // an absent signal never reports a period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tdata_i[48] |-> m_axis_tdata_i[47:32] == 16'd0)
    else $error("average period nonzero while signal absent");

endmodule

bind hall_position_speed_tracker hpst_checker u_hpst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o)
);

### sim/hall_position_speed_tracker_tb.sv
`timescale 1ns / 100ps

// self-checking bench for the hall position and speed tracker
module hall_position_speed_tracker_tb;
  import hpst_pkg::*;

  localparam int unsigned RING_DEPTH  = 4;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any transaction
  localparam int unsigned HOLD_AT     = 60;    // ops accepted before the long hold-off
  localparam int unsigned HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_OPS   = 30;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'hf;

  typedef enum logic {
    ROW_OP,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    item_t                 op_item;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
    bit                    known;
    result_t               want;
  } row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic [IN_USER_W-1:0]   s_tuser;
  logic                   m_valid;
  logic                   m_ready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // tracker mirror: counters, interval ring, warm-up and presence
  logic [15:0] pos_cnt;
  logic [15:0] trav_cnt;
  logic [15:0] prev_tick;
  logic [15:0] ring [RING_DEPTH];
  int unsigned ring_ptr;
  logic [4:0]  edges_seen;
  logic [15:0] period_sum;
  logic [7:0]  missed;
  logic        present;
  logic [7:0]  miss_lim;
  logic        up_on_high;

  result_t     pending_results [$];
  row_t        script_q [$];
  logic [15:0] timer_now = '0;
  int          ops_taken = 0;
  int          err_count = 0;
  bit          quiet = 1'b0;
  bit          offering = 1'b0;

  hall_position_speed_tracker #(
    .AVG_DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t res(logic [15:0] p, logic [15:0] t, logic [15:0] a, logic s);
    result_t r;
    r.position       = p;
    r.travel         = t;
    r.avg_period     = a;
    r.signal_present = s;
    return r;
  endfunction

  function automatic item_t mk_op(op_e op, logic dir, logic [15:0] tick, logic [15:0] val);
    item_t it;
    it.op            = op;
    it.direction     = dir;
    it.captured_tick = tick;
    it.set_value     = val;
    return it;
  endfunction

  function automatic void reset_tracker();
    pos_cnt    = POSITION_RESET;
    trav_cnt   = '0;
    prev_tick  = '0;
    foreach (ring[k]) ring[k] = '0;
    ring_ptr   = 0;
    edges_seen = '0;
    period_sum = '0;
    missed     = '0;
    present    = 1'b0;
    miss_lim   = MISS_LIMIT_RESET;
    up_on_high = 1'b1;
  endfunction

  // apply one operation to the mirror and return the state it leaves
  function automatic result_t advance_tracker(item_t it);
    logic [15:0] interval;
    logic [15:0] total;
    case (it.op)
      OP_HALL_EDGE: begin
        trav_cnt  = trav_cnt + 16'd1;
        pos_cnt   = (it.direction == up_on_high) ? pos_cnt + 16'd1 : pos_cnt - 16'd1;
        present   = 1'b1;
        missed    = '0;
        interval  = it.captured_tick - prev_tick;
        prev_tick = it.captured_tick;
        ring[ring_ptr] = 16'(interval / RING_DEPTH);
        edges_seen = edges_seen + 5'd1;
        // warmed up: the sum includes the slot written on this edge
        if (edges_seen > WARMUP_THRESHOLD) begin
          edges_seen = WARMUP_HOLD;
          total = '0;
          foreach (ring[k]) total = total + ring[k];
          period_sum = total;
        end
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
      end
      OP_MONITOR_TICK: begin
        missed = missed + 8'd1;
        // signal lost: speed measurement restarts, ring contents stay
        if (missed > miss_lim) begin
          present    = 1'b0;
          missed     = '0;
          period_sum = '0;
          prev_tick  = '0;
          edges_seen = '0;
        end
      end
      OP_SET_TRAVEL:   trav_cnt = it.set_value;
      OP_SET_POSITION: pos_cnt  = it.set_value;
      default: ;
    endcase
    return res(pos_cnt, trav_cnt, period_sum, present);
  endfunction

  // directed rows
  task automatic row_op(op_e op, logic dir, logic [15:0] tick, logic [15:0] val);
    row_t r;
    r.kind    = ROW_OP;
    r.op_item = mk_op(op, dir, tick, val);
    r.known   = 1'b0;
    r.want    = '0;
    script_q.push_back(r);
  endtask

  task automatic row_known(op_e op, logic dir, logic [15:0] tick, logic [15:0] val,
                           result_t want);
    row_t r;
    r.kind    = ROW_OP;
    r.op_item = mk_op(op, dir, tick, val);
    r.known   = 1'b1;
    r.want    = want;
    script_q.push_back(r);
  endtask

  task automatic row_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.reg_data  = data;
    script_q.push_back(r);
  endtask

  task automatic build_script();
    // reset values show through a tick that stays under the limit
    row_known(OP_MONITOR_TICK, 1'b0, 16'h0000, 16'h0000, res(16'h5000, 16'h0, 16'h0, 1'b0));
    row_known(OP_SET_POSITION, 1'b0, 16'h0000, 16'hffff, res(16'hffff, 16'h0, 16'h0, 1'b0));
    // position wraps both ways
    row_known(OP_HALL_EDGE, 1'b1, 16'h0010, 16'h0000, res(16'h0000, 16'h1, 16'h0, 1'b1));
    row_known(OP_HALL_EDGE, 1'b0, 16'hffff, 16'h0000, res(16'hffff, 16'h2, 16'h0, 1'b1));
    row_known(OP_SET_TRAVEL, 1'b0, 16'h0000, 16'hffff, res(16'hffff, 16'hffff, 16'h0, 1'b1));
    // travel wraps, tick interval wraps across zero
    row_known(OP_HALL_EDGE, 1'b1, 16'h0003, 16'h0000, res(16'h0000, 16'h0, 16'h0, 1'b1));
    // unused fields must not leak in
    row_known(OP_SET_TRAVEL, 1'b1, 16'habcd, 16'h0000, res(16'h0000, 16'h0, 16'h0, 1'b1));
    row_known(OP_SET_POSITION, 1'b1, 16'hffff, 16'h1234, res(16'h1234, 16'h0, 16'h0, 1'b1));
    row_known(OP_MONITOR_TICK, 1'b1, 16'hffff, 16'hffff, res(16'h1234, 16'h0, 16'h0, 1'b1));
    // inverted polarity
    row_reg(REG_COUNT_UP_ON_HIGH, 8'h00);
    row_known(OP_HALL_EDGE, 1'b1, 16'h1234, 16'hffff, res(16'h1233, 16'h1, 16'h0, 1'b1));
    row_known(OP_HALL_EDGE, 1'b0, 16'h2345, 16'h0000, res(16'h1234, 16'h2, 16'h0, 1'b1));
    // zero limit: first tick loses the signal
    row_reg(REG_MISS_LIMIT, 8'h00);
    row_known(OP_MONITOR_TICK, 1'b0, 16'h0000, 16'h0000, res(16'h1234, 16'h2, 16'h0, 1'b0));
    row_op(OP_HALL_EDGE, 1'b0, 16'h0000, 16'h0000);
    // limit at maximum never declares loss
    row_reg(REG_MISS_LIMIT, 8'hff);
    row_op(OP_MONITOR_TICK, 1'b0, 16'h0000, 16'h0000);
    // write to an unused index is dropped
    row_reg(REG_UNUSED, 8'h00);
    row_known(OP_MONITOR_TICK, 1'b0, 16'h0000, 16'h0000, res(16'h1235, 16'h3, 16'h0, 1'b1));
    // only bit 0 of the polarity write counts
    row_reg(REG_COUNT_UP_ON_HIGH, 8'hff);
    row_known(OP_HALL_EDGE, 1'b1, 16'hffff, 16'h0000, res(16'h1236, 16'h4, 16'h0, 1'b1));
  endtask

  // drop valid and let the pipeline drain before touching registers
  task automatic wait_idle();
    if (offering) s_valid <= 1'b0;
    offering = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_MISS_LIMIT) miss_lim = data;
    else if (idx == REG_COUNT_UP_ON_HIGH) up_on_high = data[0];
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // both registers back to back, valid held high between the two transactions
  task automatic write_both(logic [7:0] lim, logic [7:0] pol);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MISS_LIMIT;
    cfg_data  <= lim;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(REG_MISS_LIMIT, lim);
    cfg_index <= REG_COUNT_UP_ON_HIGH;
    cfg_data  <= pol;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(REG_COUNT_UP_ON_HIGH, pol);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_op(item_t it, bit known = 1'b0, result_t want = '0);
    result_t pred;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      if (offering) s_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_valid  <= 1'b1;
    s_tdata  <= {7'd0, it.set_value, it.captured_tick, it.direction};
    s_tuser  <= it.op;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_ready);
    pred = advance_tracker(it);
    pending_results.push_back(known ? want : pred);
    ops_taken++;
  endtask

  task automatic send_noise();
    send_op(mk_op(op_e'($urandom_range(0, 3)), 1'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  // a stream of edges with tolerated gaps of monitor ticks and occasional set operations
  task automatic edge_run(int unsigned n);
    int unsigned pick;
    int unsigned gap;
    logic [15:0] step;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) step = 16'($urandom_range(1, 400));
      else if (pick < 95) step = 16'($urandom_range(400, 20000));
      else step = 16'($urandom);
      timer_now = timer_now + step;
      send_op(mk_op(OP_HALL_EDGE, 1'($urandom), timer_now, 16'($urandom)));
      if (miss_lim != 0 && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, (miss_lim > 20) ? 20 : miss_lim);
        repeat (gap) send_op(mk_op(OP_MONITOR_TICK, 1'($urandom), 16'($urandom),
                                   16'($urandom)));
      end
      if ($urandom_range(0, 15) == 0)
        send_op(mk_op(op_e'($urandom_range(2, 3)), 1'($urandom), 16'($urandom),
                      16'($urandom)));
    end
  endtask

  // enough ticks to pass the limit; at the maximum the count wraps instead
  task automatic loss_burst();
    int unsigned n;
    n = miss_lim + 1 + $urandom_range(0, 1);
    repeat (n) send_op(mk_op(OP_MONITOR_TICK, 1'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned left;
    int unsigned n;
    stop_at = ops_taken + budget;
    while (ops_taken < stop_at) begin
      left = stop_at - ops_taken;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(30, 45);
        edge_run((n > left) ? left : n);
      end
      else if (pick < 72 && miss_lim + 2 <= left) loss_burst();
      else if (pick < 88)
        send_op(mk_op(op_e'($urandom_range(2, 3)), 1'($urandom), 16'($urandom),
                      16'($urandom)));
      else repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  initial begin : stimulus
    logic [7:0] lim;
    s_valid   <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_ni    <= 1'b0;
    reset_tracker();
    build_script();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script_q[i]) begin
      if (script_q[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(script_q[i].reg_index, script_q[i].reg_data);
      end else begin
        send_op(script_q[i].op_item, script_q[i].known, script_q[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: lim = 8'd0;
        1: lim = 8'd254;
        2: lim = 8'd255;
        3: lim = 8'($urandom_range(1, 12));
        4: lim = MISS_LIMIT_RESET;
        default: lim = 8'($urandom_range(0, 20));
      endcase
      wait_idle();
      quiet = (p == PHASES - 1);
      write_both(lim, 8'($urandom_range(0, 127) * 2 + (p % 2)));
      // the two largest limits take one full run of ticks to reach or wrap
      if (lim >= 8'd254) loss_burst();
      random_phase(PHASE_OPS);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // receiver: random stalls plus one long hold-off that backs up the input
  initial begin : result_sink
    bit held;
    held = 1'b0;
    m_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && ops_taken >= HOLD_AT) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
      err_count++;
    end
  endfunction

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: 0x%h", m_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("position", want.position, m_tdata[15:0]);
        check_field("travel", want.travel, m_tdata[31:16]);
        check_field("avg_period", want.avg_period, m_tdata[47:32]);
        check_field("signal_present", 16'(want.signal_present), 16'(m_tdata[48]));
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
